/* rtl/bblru_pkg.sv */
// Shared constants for the byte-budget LRU cache.
package bblru_pkg;
  localparam int unsigned EntriesDef    = 16;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned HandleBitsDef = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned SizeW   = 24;
  localparam int unsigned CapW    = 32;
  localparam int unsigned OccW    = 33;
  localparam int unsigned EvW     = 5;

  localparam logic [KindW-1:0] KindLookup = 2'd0;
  localparam logic [KindW-1:0] KindInsert = 2'd1;
  localparam logic [KindW-1:0] KindClear  = 2'd2;
  localparam logic [KindW-1:0] KindNop    = 2'd3;
endpackage

/* rtl/byte_budget_lru_cache.sv */
// Top level of the byte-budget LRU cache.
// Command channel: pulse start_i with kind_i, key_i, handle_i, item_bytes_i while
// busy_o is low; the beat is taken at that edge and busy_o rises for the work.
// kind 0 looks up a key, 1 inserts, 2 clears every slot, 3 does nothing.
// Result channel: done_o is high for one cycle with hit_o, handle_out_o,
// stored_o, evicted_count_o and occupancy_o; the receiver cannot stall it,
// so the result is simply presented for that one cycle.
// A scan walks the slots one a cycle through a single key compare and rank
// compare. A lookup hit or an admitted insert takes one scan plus an update
// pass over the slots; each eviction costs another scan. Clear and no-op go
// straight to the done state.
// Capacity is written through cfg_we_i / cfg_wdata_i; the user writes it only
// while idle, as the block does not enforce this. Reset clears valid bits,
// ranks, occupancy and capacity; slot payload memories are not cleared and
// are only read for valid slots.
module byte_budget_lru_cache #(
  parameter int unsigned Entries    = bblru_pkg::EntriesDef,
  parameter int unsigned KeyBits    = bblru_pkg::KeyBitsDef,
  parameter int unsigned HandleBits = bblru_pkg::HandleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [bblru_pkg::KindW-1:0]  kind_i,
  input  logic [bblru_pkg::KeyW-1:0]   key_i,
  input  logic [bblru_pkg::HandleW-1:0] handle_i,
  input  logic [bblru_pkg::SizeW-1:0]  item_bytes_i,
  input  logic                         cfg_we_i,
  input  logic [bblru_pkg::CapW-1:0]   cfg_wdata_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [bblru_pkg::HandleW-1:0] handle_out_o,
  output logic                         stored_o,
  output logic [bblru_pkg::EvW-1:0]    evicted_count_o,
  output logic [bblru_pkg::OccW-1:0]   occupancy_o
);
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned HbW  = (HandleBits < bblru_pkg::HandleW) ?
                                 HandleBits : bblru_pkg::HandleW;
  localparam int unsigned KbW  = (KeyBits < bblru_pkg::KeyW) ? KeyBits : bblru_pkg::KeyW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Entries);

  typedef enum logic [2:0] {
    StIdle, StScan, StDecide, StEvict, StUpdate, StDone
  } state_e;

  state_e state_q;
  logic [bblru_pkg::CapW-1:0]   cap_q;
  logic [bblru_pkg::OccW-1:0]   occ_q;
  logic [Entries-1:0]           valid_q;
  logic [IdxW-1:0]              rank_q [Entries];
  logic [CntW-1:0]              nvalid_q;
  logic [bblru_pkg::KindW-1:0]  kind_q;
  logic [KeyBits-1:0]           key_q;
  logic [HandleBits-1:0]        hnd_q;
  logic [bblru_pkg::SizeW-1:0]  bytes_q;
  logic [IdxW-1:0]              idx_q;
  logic                         ins_q;     // insert past the presence check
  logic [IdxW-1:0]              tgt_q;     // hit slot or free slot to fill
  logic [IdxW-1:0]              hrank_q;
  logic [bblru_pkg::EvW-1:0]    ev_q;

  logic [KeyBits-1:0]           mem_key  [Entries];
  logic [HandleBits-1:0]        mem_hnd  [Entries];
  logic [bblru_pkg::SizeW-1:0]  mem_size [Entries];

  logic scan_clr, scan_en, match, lru_found;
  logic [IdxW-1:0] match_idx, lru_idx;
  logic [KeyBits-1:0] key_ext;

  assign busy_o  = (state_q != StIdle);
  assign key_ext = KeyBits'(key_i[KbW-1:0]);
  assign scan_clr = (state_q == StIdle) || (state_q == StEvict);
  assign scan_en  = (state_q == StScan);

  bblru_scan #(.Entries(Entries), .KeyBits(KeyBits)) u_scan (
    .clk_i, .rst_ni,
    .clr_i       (scan_clr),
    .en_i        (scan_en),
    .idx_i       (idx_q),
    .valid_i     (valid_q[idx_q]),
    .key_i       (key_q),
    .slot_key_i  (mem_key[idx_q]),
    .rank_i      (rank_q[idx_q]),
    .match_o     (match),
    .match_idx_o (match_idx),
    .lru_found_o (lru_found),
    .lru_idx_o   (lru_idx)
  );

  // free slot search: first invalid slot (priority over valid bits)
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  logic [bblru_pkg::OccW-1:0] occ_cap, lru_sz;
  assign occ_cap = bblru_pkg::OccW'(cap_q);
  assign lru_sz  = bblru_pkg::OccW'(mem_size[lru_idx]);

  always_ff @(posedge clk_i) begin
    if (state_q == StUpdate && ins_q && idx_q == LastIdx) begin
      mem_key[tgt_q]  <= key_q;
      mem_hnd[tgt_q]  <= hnd_q;
      mem_size[tgt_q] <= bytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cap_q    <= '0;
      occ_q    <= '0;
      valid_q  <= '0;
      nvalid_q <= '0;
      for (int i = 0; i < Entries; i++) rank_q[i] <= '0;
      kind_q   <= '0;
      key_q    <= '0;
      hnd_q    <= '0;
      bytes_q  <= '0;
      idx_q    <= '0;
      ins_q    <= 1'b0;
      tgt_q    <= '0;
      hrank_q  <= '0;
      ev_q     <= '0;
      done_o          <= 1'b0;
      hit_o           <= 1'b0;
      handle_out_o    <= '0;
      stored_o        <= 1'b0;
      evicted_count_o <= '0;
      occupancy_o     <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            kind_q  <= kind_i;
            key_q   <= key_ext;
            hnd_q   <= HandleBits'(handle_i[HbW-1:0]);
            bytes_q <= item_bytes_i;
            idx_q   <= '0;
            ins_q   <= 1'b0;
            ev_q    <= '0;
            if (kind_i == bblru_pkg::KindLookup || kind_i == bblru_pkg::KindInsert) begin
              state_q <= StScan;
            end else begin
              if (kind_i == bblru_pkg::KindClear) begin
                valid_q  <= '0;
                nvalid_q <= '0;
                occ_q    <= '0;
                for (int i = 0; i < Entries; i++) rank_q[i] <= '0;
              end
              state_q <= StDone;
            end
          end
        end
        StScan: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (kind_q == bblru_pkg::KindLookup) begin
            if (match) begin
              tgt_q   <= match_idx;
              hrank_q <= rank_q[match_idx];
              state_q <= StUpdate;
            end else begin
              state_q <= StDone;
            end
          end else if (!ins_q) begin
            // after presence scan: admit and add size unless hit or zero budget
            if (match || cap_q == '0) begin
              state_q <= StDone;
            end else begin
              ins_q   <= 1'b1;
              occ_q   <= occ_q + bblru_pkg::OccW'(bytes_q);
              state_q <= StEvict;
            end
          end else begin
            // LRU scan done: evict if over budget, or if every slot is full
            if (lru_found && (occ_q > occ_cap || nvalid_q == FullCnt)) begin
              valid_q[lru_idx] <= 1'b0;
              nvalid_q <= nvalid_q - 1'b1;
              ev_q     <= ev_q + 1'b1;
              if (nvalid_q == CntW'(1)) occ_q <= bblru_pkg::OccW'(bytes_q);
              else if (occ_q >= lru_sz) occ_q <= occ_q - lru_sz;
              else occ_q <= '0;
              state_q <= StEvict;
            end else begin
              tgt_q   <= free_idx;
              state_q <= StUpdate;
            end
          end
        end
        StEvict: begin
          // rescan for the next least recent slot, or move on
          if (occ_q > occ_cap || nvalid_q == FullCnt) begin
            idx_q   <= '0;
            state_q <= StScan;
          end else begin
            tgt_q   <= free_idx;
            state_q <= StUpdate;
          end
        end
        StUpdate: begin
          // age ranks one slot per cycle
          if (kind_q == bblru_pkg::KindLookup) begin
            if (idx_q == tgt_q) rank_q[idx_q] <= '0;
            else if (valid_q[idx_q] && rank_q[idx_q] < hrank_q)
              rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
          end else if (valid_q[idx_q]) begin
            rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            if (kind_q == bblru_pkg::KindInsert && free_found) begin
              valid_q[tgt_q] <= 1'b1;
              rank_q[tgt_q]  <= '0;
              nvalid_q       <= nvalid_q + 1'b1;
              if (nvalid_q == '0) occ_q <= bblru_pkg::OccW'(bytes_q);
            end else if (kind_q == bblru_pkg::KindInsert) begin
              ins_q <= 1'b0;
            end
            state_q <= StDone;
          end
        end
        StDone: begin
          done_o          <= 1'b1;
          hit_o           <= (kind_q == bblru_pkg::KindLookup) && match;
          handle_out_o    <= ((kind_q == bblru_pkg::KindLookup) && match) ?
                             bblru_pkg::HandleW'(mem_hnd[match_idx]) : '0;
          stored_o        <= (kind_q == bblru_pkg::KindInsert) && ins_q;
          evicted_count_o <= ev_q;
          occupancy_o     <= occ_q;
          state_q         <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

/* rtl/bblru_scan.sv */
// Slot scanner: one slot per cycle, finds a key match and the least recent slot.
module bblru_scan #(
  parameter int unsigned Entries = bblru_pkg::EntriesDef,
  parameter int unsigned KeyBits = bblru_pkg::KeyBitsDef,
  localparam int unsigned IdxW = $clog2(Entries)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic [IdxW-1:0]    idx_i,
  input  logic               valid_i,
  input  logic [KeyBits-1:0] key_i,
  input  logic [KeyBits-1:0] slot_key_i,
  input  logic [IdxW-1:0]    rank_i,
  output logic               match_o,
  output logic [IdxW-1:0]    match_idx_o,
  output logic               lru_found_o,
  output logic [IdxW-1:0]    lru_idx_o
);
  logic [IdxW-1:0] lru_rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_o     <= 1'b0;
      match_idx_o <= '0;
      lru_found_o <= 1'b0;
      lru_idx_o   <= '0;
      lru_rank_q  <= '0;
    end else if (clr_i) begin
      match_o     <= 1'b0;
      lru_found_o <= 1'b0;
    end else if (en_i && valid_i) begin
      if (!match_o && slot_key_i == key_i) begin
        match_o     <= 1'b1;
        match_idx_o <= idx_i;
      end
      // keep the first slot on a rank tie, as a strict compare does
      if (!lru_found_o || rank_i > lru_rank_q) begin
        lru_found_o <= 1'b1;
        lru_idx_o   <= idx_i;
        lru_rank_q  <= rank_i;
      end
    end
  end
endmodule

/* bench/tb_byte_budget_lru_cache.sv */
// Self-checking testbench for the byte-budget LRU cache.
module tb_byte_budget_lru_cache;

  localparam int unsigned Slots     = bblru_pkg::EntriesDef;
  // Idle cycles without any beat before the run is declared hung. The worst insert is
  // about Slots evictions, each with a rescan, plus two passes, well under this.
  localparam int unsigned HangLimit = 4000;

  typedef struct packed {
    logic                          hit;
    logic [bblru_pkg::HandleW-1:0] handle_out;
    logic                          stored;
    logic [bblru_pkg::EvW-1:0]     evicted;
    logic [bblru_pkg::OccW-1:0]    occupancy;
  } cache_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic [bblru_pkg::KindW-1:0]   kind_i = bblru_pkg::KindLookup;
  logic [bblru_pkg::KeyW-1:0]    key_i = '0;
  logic [bblru_pkg::HandleW-1:0] handle_i = '0;
  logic [bblru_pkg::SizeW-1:0]   item_bytes_i = '0;
  logic                          cfg_we_i = 1'b0;
  logic [bblru_pkg::CapW-1:0]    cfg_wdata_i = '0;
  logic                          busy_o;
  logic                          done_o;
  logic                          hit_o;
  logic [bblru_pkg::HandleW-1:0] handle_out_o;
  logic                          stored_o;
  logic [bblru_pkg::EvW-1:0]     evicted_count_o;
  logic [bblru_pkg::OccW-1:0]    occupancy_o;

  byte_budget_lru_cache uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .kind_i, .key_i, .handle_i, .item_bytes_i,
    .cfg_we_i, .cfg_wdata_i, .done_o, .hit_o, .handle_out_o, .stored_o,
    .evicted_count_o, .occupancy_o
  );

  // Shadow copy of the cache table, kept in step with every accepted beat.
  logic [bblru_pkg::KeyW-1:0]    shadow_key    [Slots];
  logic [bblru_pkg::HandleW-1:0] shadow_handle [Slots];
  logic [bblru_pkg::SizeW-1:0]   shadow_size   [Slots];
  logic                          shadow_valid  [Slots];
  int unsigned                   shadow_rank   [Slots];
  logic [bblru_pkg::OccW-1:0]    shadow_occ;
  logic [bblru_pkg::CapW-1:0]    shadow_cap;

  cache_result_t       pending_results[$];
  int unsigned         errors = 0;
  int unsigned         quiet_cycles = 0;
  bit                  beat_taken;

  // Sender pacing: bursts of back-to-back beats, then a gap.
  bit                  gaps_on = 1'b1;
  int unsigned         burst_left = 0;

  // Key pool so lookups and duplicate inserts actually hit.
  logic [bblru_pkg::KeyW-1:0] key_pool[24];

  initial forever #5 clk_i = ~clk_i;

  function automatic int find_slot(logic [bblru_pkg::KeyW-1:0] k);
    for (int i = 0; i < Slots; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < Slots; i++)
      if (shadow_valid[i] && (best < 0 || shadow_rank[i] > shadow_rank[best])) best = i;
    return best;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) n += shadow_valid[i];
    return n;
  endfunction

  function automatic void drop_slot(int s);
    logic [bblru_pkg::OccW-1:0] sz;
    sz = bblru_pkg::OccW'(shadow_size[s]);
    shadow_occ = (shadow_occ >= sz) ? shadow_occ - sz : '0;
    shadow_valid[s] = 1'b0;
  endfunction

  // Apply one command to the shadow table and return the result the block must give.
  function automatic cache_result_t apply_command(logic [bblru_pkg::KindW-1:0] kind,
                                                  logic [bblru_pkg::KeyW-1:0] k,
                                                  logic [bblru_pkg::HandleW-1:0] h,
                                                  logic [bblru_pkg::SizeW-1:0] b);
    cache_result_t r;
    int s;
    int unsigned rk;
    r = '0;
    case (kind)
      bblru_pkg::KindLookup: begin
        s = find_slot(k);
        if (s >= 0) begin
          rk = shadow_rank[s];
          for (int i = 0; i < Slots; i++)
            if (shadow_valid[i] && shadow_rank[i] < rk) shadow_rank[i]++;
          shadow_rank[s] = 0;
          r.hit = 1'b1;
          r.handle_out = shadow_handle[s];
        end
      end
      bblru_pkg::KindInsert: begin
        if (find_slot(k) < 0 && shadow_cap != '0) begin
          shadow_occ += bblru_pkg::OccW'(b);
          while (shadow_occ > bblru_pkg::OccW'(shadow_cap)) begin
            s = oldest_slot();
            if (s < 0) break;
            drop_slot(s);
            r.evicted++;
          end
          if (live_count() == 0) shadow_occ = bblru_pkg::OccW'(b);
          if (live_count() >= Slots) begin
            s = oldest_slot();
            if (s >= 0) begin
              drop_slot(s);
              r.evicted++;
            end
          end
          s = -1;
          for (int i = 0; i < Slots; i++) begin
            if (!shadow_valid[i]) begin
              if (s < 0) s = i;
            end else begin
              shadow_rank[i]++;
            end
          end
          if (s >= 0) begin
            shadow_key[s] = k;
            shadow_handle[s] = h;
            shadow_size[s] = b;
            shadow_valid[s] = 1'b1;
            shadow_rank[s] = 0;
            r.stored = 1'b1;
          end
        end
      end
      bblru_pkg::KindClear: begin
        for (int i = 0; i < Slots; i++) begin
          shadow_valid[i] = 1'b0;
          shadow_rank[i] = 0;
        end
        shadow_occ = '0;
      end
      default: ;
    endcase
    r.occupancy = shadow_occ;
    return r;
  endfunction

  // Present one command beat, hold it until taken, then maybe open a gap.
  task automatic send_command(logic [bblru_pkg::KindW-1:0] kind,
                              logic [bblru_pkg::KeyW-1:0] k,
                              logic [bblru_pkg::HandleW-1:0] h,
                              logic [bblru_pkg::SizeW-1:0] b);
    int unsigned gap;
    start_i      <= 1'b1;
    kind_i       <= kind;
    key_i        <= k;
    handle_i     <= h;
    item_bytes_i <= b;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_command(kind, k, h, b));
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every result is back and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [bblru_pkg::CapW-1:0] cap);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    shadow_cap = cap;
    cfg_we_i <= 1'b0;
  endtask

  // Result checker: the block gives each result for one cycle only.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      cache_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, got hit=%b handle=%h stored=%b ev=%0d occ=%h",
                 $time, hit_o, handle_out_o, stored_o, evicted_count_o, occupancy_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, hit_o);
          errors++;
        end
        if (handle_out_o !== want.handle_out) begin
          $display("%0t: handle_out expected %h actual %h", $time, want.handle_out,
                   handle_out_o);
          errors++;
        end
        if (stored_o !== want.stored) begin
          $display("%0t: stored expected %b actual %b", $time, want.stored, stored_o);
          errors++;
        end
        if (evicted_count_o !== want.evicted) begin
          $display("%0t: evicted_count expected %0d actual %0d", $time, want.evicted,
                   evicted_count_o);
          errors++;
        end
        if (occupancy_o !== want.occupancy) begin
          $display("%0t: occupancy expected %h actual %h", $time, want.occupancy,
                   occupancy_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: advance while beats move in either direction, bail out on a hang.
  always @(posedge clk_i) begin
    beat_taken = (start_i && !busy_o) || done_o;
    if (!rst_ni || beat_taken) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("byte_budget_lru_cache test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic fill_key_pool();
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
  endtask

  // Directed corner cases: disabled budget, hits, misses, duplicates, oversize items,
  // the spare opcode, clear, and slot exhaustion with zero-byte items.
  task automatic test_directed();
    gaps_on = 1'b0;
    send_command(bblru_pkg::KindInsert, 32'h1234, 16'hAAAA, 24'd10);   // budget zero: ignored
    write_capacity(32'd100);
    send_command(bblru_pkg::KindInsert, 32'h0, 16'h0001, 24'd40);
    send_command(bblru_pkg::KindInsert, 32'hFFFF_FFFF, 16'hFFFF, 24'd50);
    send_command(bblru_pkg::KindInsert, 32'h0, 16'h5555, 24'd5);        // duplicate key
    send_command(bblru_pkg::KindLookup, 32'h0, '0, '0);                 // hit, promote
    send_command(bblru_pkg::KindLookup, 32'hDEAD_BEEF, '0, '0);         // miss
    send_command(bblru_pkg::KindInsert, 32'h77, 16'h0077, 24'd30);      // evicts older entry
    send_command(bblru_pkg::KindInsert, 32'h88, 16'h0088, 24'hFF_FFFF); // oversize
    send_command(bblru_pkg::KindNop, 32'h88, 16'hFFFF, 24'hFF_FFFF);    // spare opcode
    send_command(bblru_pkg::KindLookup, 32'h88, '0, '0);
    send_command(bblru_pkg::KindClear, '0, '0, '0);
    send_command(bblru_pkg::KindLookup, 32'h88, '0, '0);
    for (int i = 0; i < 17; i++)                                        // slot exhaustion
      send_command(bblru_pkg::KindInsert, 32'h100 + i, 16'(i), 24'd0);
    send_command(bblru_pkg::KindLookup, 32'h100, '0, '0);
    send_command(bblru_pkg::KindLookup, 32'h110, '0, '0);
    gaps_on = 1'b1;
  endtask

  // One random phase under a given budget; most items hit the key pool.
  task automatic test_random_budget(logic [bblru_pkg::CapW-1:0] cap, int unsigned count,
                                    bit gaps);
    int unsigned pick;
    logic [bblru_pkg::KindW-1:0] kind;
    logic [bblru_pkg::KeyW-1:0] k;
    logic [bblru_pkg::SizeW-1:0] b;
    logic [31:0] size_top;
    write_capacity(cap);
    fill_key_pool();
    gaps_on = gaps;
    size_top = (cap / 6 > 32'hFF_FFFF) ? 32'hFF_FFFF : cap / 6 + 1;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = bblru_pkg::KindInsert;
      else if (pick < 92) kind = bblru_pkg::KindLookup;
      else if (pick < 96) kind = bblru_pkg::KindClear;
      else kind = bblru_pkg::KindNop;
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
      b = ($urandom_range(0, 15) == 0) ? bblru_pkg::SizeW'($urandom) :
                                         bblru_pkg::SizeW'($urandom_range(0, size_top));
      send_command(kind, k, bblru_pkg::HandleW'($urandom), b);
    end
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_occ = '0;
    shadow_cap = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_budget(32'd1, 150, 1'b1);
    test_random_budget(32'd600, 300, 1'b1);
    test_random_budget(32'd20000, 300, 1'b0);
    test_random_budget(32'hFFFF_FFFF, 250, 1'b1);
    test_random_budget(32'd0, 100, 1'b1);
    test_random_budget(32'd40_000_000, 200, 1'b1);
    test_random_budget($urandom_range(1, 5000), 230, 1'b1);

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("byte_budget_lru_cache test passed");
    end else begin
      $display("byte_budget_lru_cache test failed");
    end
    $finish;
  end
endmodule
